### src/cdcb_pkg.sv
// Shared constants, types and helper functions for the chunk boundary finder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package cdcb_pkg;

	localparam int WINDOW_LEN  = 16;
	localparam int MAX_LEN     = 1048576;
	localparam int COUNT_W     = $clog2(MAX_LEN);
	localparam int POS_W       = 20;
	localparam int BYTE_W      = 8;
	localparam int HASH_W      = 8;
	localparam int HASH_BASE   = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_MATCH_TARGET = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_MASK   = CFG_IDX_W'(1);

	localparam logic [HASH_W-1:0] TARGET_RESET = HASH_W'(0);
	localparam logic [HASH_W-1:0] MASK_RESET   = HASH_W'(255);

	function automatic logic [HASH_W-1:0] pow_base(input int n);
		logic [HASH_W-1:0] acc;
		acc = HASH_W'(1);
		for (int i = 0; i < n; i++) begin
			acc = HASH_W'(int'(acc) * HASH_BASE);
		end
		return acc;
	endfunction

	// Weight of the byte that leaves the window, after the whole hash is scaled by the base.
	localparam logic [HASH_W-1:0] DROP_WEIGHT = pow_base(WINDOW_LEN + 1);

	typedef enum logic [1:0] {
		KIND_SKIP,
		KIND_TEST,
		KIND_FINAL
	} item_kind_t;

	typedef struct packed {
		item_kind_t        kind;
		logic [POS_W-1:0]  pos;
		logic [HASH_W-1:0] hash;
	} cdcb_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

`default_nettype wire

### src/content_defined_chunk_boundary_core.sv
// A byte accepted by the front end is written into the queue; its boundary word, if any,
// is loaded from the queue head into the output register when the back end pops the entry.
// Throughput: one byte per cycle when not stalled, set by the combinational rolling hash update.
// The four-entry queue lets input continue while a result waits; input stalls only when full.
// Reset clears the window, byte count, hash, queue and output; match_target resets to 0 and
// match_mask to 255. No clearing pass is needed after reset.
`default_nettype none

module content_defined_chunk_boundary_core import cdcb_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [BYTE_W-1:0]     data_byte,
	input  wire logic                  is_last,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [POS_W-1:0]           boundary_pos,
	output logic                       is_final
);

	queue_status_t q_status;
	cdcb_entry_t   push_entry;
	cdcb_entry_t   head;
	logic          push;
	logic          pop;

	cdcb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.is_last   (is_last),
		.q_status  (q_status),
		.q_push    (push),
		.q_entry   (push_entry)
	);

	cdcb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	cdcb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_status     (q_status),
		.q_head       (head),
		.q_pop        (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.boundary_pos (boundary_pos),
		.is_final     (is_final)
	);

endmodule

`default_nettype wire

### src/cdcb_front.sv
// Front end: accepts bytes, keeps the window, byte count and rolling hash,
// and classifies each word for the queue. Depends on cdcb_pkg.
`default_nettype none

module cdcb_front import cdcb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              is_last,
	input  wire queue_status_t     q_status,
	output logic                   q_push,
	output cdcb_entry_t            q_entry
);

	logic [BYTE_W-1:0]  win_q [WINDOW_LEN];
	logic [COUNT_W-1:0] cnt_q;
	logic [HASH_W-1:0]  hash_q;
	logic [HASH_W-1:0]  hash_next;
	logic [HASH_W-1:0]  scaled_old;
	logic [HASH_W-1:0]  scaled_new;
	logic [HASH_W-1:0]  dropped;
	logic               accept;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !q_status.full;
	assign q_push   = accept;

	assign scaled_old = HASH_W'({hash_q, 1'b0}) + hash_q;
	assign scaled_new = HASH_W'({data_byte, 1'b0}) + HASH_W'(data_byte);
	assign dropped    = HASH_W'(win_q[0] * DROP_WEIGHT);
	assign hash_next  = HASH_W'(scaled_old + scaled_new - dropped);

	always_comb begin
		q_entry.hash = hash_next;
		if (is_last) begin
			q_entry.kind = KIND_FINAL;
			q_entry.pos  = POS_W'(cnt_q);
		end else if (cnt_q >= COUNT_W'(2 * WINDOW_LEN - 1)) begin
			q_entry.kind = KIND_TEST;
			q_entry.pos  = POS_W'(cnt_q - COUNT_W'(WINDOW_LEN));
		end else begin
			q_entry.kind = KIND_SKIP;
			q_entry.pos  = POS_W'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			hash_q <= '0;
			for (int i = 0; i < WINDOW_LEN; i++) begin
				win_q[i] <= '0;
			end
		end else if (accept) begin
			if (is_last) begin
				cnt_q  <= '0;
				hash_q <= '0;
				for (int i = 0; i < WINDOW_LEN; i++) begin
					win_q[i] <= '0;
				end
			end else begin
				if (cnt_q != COUNT_W'(MAX_LEN - 1)) begin
					cnt_q <= cnt_q + COUNT_W'(1);
				end
				hash_q <= hash_next;
				for (int i = 0; i < WINDOW_LEN - 1; i++) begin
					win_q[i] <= win_q[i + 1];
				end
				win_q[WINDOW_LEN - 1] <= data_byte;
			end
		end
	end

endmodule

`default_nettype wire

### src/cdcb_queue.sv
// Short first-in first-out queue between the front and back ends.
// Holds classified words; depends on cdcb_pkg.
`default_nettype none

module cdcb_queue import cdcb_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cdcb_entry_t   push_entry,
	input  wire logic          pop,
	output cdcb_entry_t        head,
	output queue_status_t      status
);

	cdcb_entry_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign status.full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

### src/cdcb_back.sv
// Back end: holds the match registers, tests queued words and drives the
// registered result channel. Depends on cdcb_pkg.
`default_nettype none

module cdcb_back import cdcb_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire queue_status_t         q_status,
	input  wire cdcb_entry_t           q_head,
	output logic                       q_pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [POS_W-1:0]           boundary_pos,
	output logic                       is_final
);

	logic [HASH_W-1:0] target_q;
	logic [HASH_W-1:0] mask_q;
	logic              out_valid_q;
	logic [POS_W-1:0]  pos_q;
	logic              final_q;
	logic              emit;

	assign q_pop        = !q_status.empty && (!out_valid_q || !out_stall);
	assign out_valid    = out_valid_q;
	assign boundary_pos = pos_q;
	assign is_final     = final_q;

	always_comb begin
		unique case (q_head.kind)
			KIND_FINAL: emit = 1'b1;
			KIND_TEST:  emit = ((q_head.hash & mask_q) == target_q);
			default:    emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
			mask_q   <= MASK_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MATCH_TARGET: target_q <= HASH_W'(cfg_data);
				REG_MATCH_MASK:   mask_q   <= HASH_W'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			pos_q   <= q_head.pos;
			final_q <= (q_head.kind == KIND_FINAL);
		end
	end

endmodule

`default_nettype wire

### src/cdcb_checker.sv
// Port-level assertions for the chunk boundary finder and their bind to the top level.
// Depends on cdcb_pkg and content_defined_chunk_boundary_core.
`default_nettype none

module cdcb_assertions import cdcb_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [POS_W-1:0]  boundary_pos,
	input wire logic              is_final
);

	// A stalled result word holds its value until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(boundary_pos) && $stable(is_final))
		else $error("result word changed while stalled");

	// An inner boundary always lies at least one window into the buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_final |-> boundary_pos >= POS_W'(WINDOW_LEN - 1))
		else $error("inner boundary lies before the first full window");

	// The input side can only back up while the output side is holding a word.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stalled without back pressure on the output");

endmodule

bind content_defined_chunk_boundary_core cdcb_assertions u_cdcb_assertions (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.boundary_pos (boundary_pos),
	.is_final     (is_final)
);

`default_nettype wire

### tb/sv/cdcb_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the chunk boundary finder: follows the byte window and the match registers,
// predicts each boundary word and compares it with what the block delivers. Uses cdcb_pkg.
module cdcb_checker import cdcb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [BYTE_W-1:0]     data_byte,
	input  logic                  is_last,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [POS_W-1:0]      boundary_pos,
	input  logic                  is_final,
	output int                    mismatch_count,
	output int                    pending_count,
	output int                    bytes_seen,
	output int                    cuts_seen,
	output int                    finals_seen
);

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             fin;
	} boundary_t;

	logic [BYTE_W-1:0]  window_q [WINDOW_LEN];
	logic [COUNT_W-1:0] next_index;
	logic [HASH_W-1:0]  cut_target;
	logic [HASH_W-1:0]  cut_mask;
	boundary_t          boundary_fifo [$];
	int                 errors;
	int                 byte_total;
	int                 cut_total;
	int                 final_total;

	function automatic logic [HASH_W-1:0] rolling_sum();
		logic [HASH_W-1:0] acc;
		logic [HASH_W-1:0] weight;
		acc = '0;
		weight = HASH_W'(HASH_BASE);
		for (int j = 0; j < WINDOW_LEN; j++) begin
			acc = acc + window_q[WINDOW_LEN - 1 - j] * weight;
			weight = weight * HASH_W'(HASH_BASE);
		end
		return acc;
	endfunction

	function automatic logic absorb_byte(input logic [BYTE_W-1:0] b, input logic l,
			output boundary_t res);
		logic found;
		found = 1'b0;
		res = '0;
		for (int i = 0; i < WINDOW_LEN - 1; i++) window_q[i] = window_q[i + 1];
		window_q[WINDOW_LEN - 1] = b;
		if (l) begin
			res.pos = next_index;
			res.fin = 1'b1;
			found = 1'b1;
			next_index = '0;
			foreach (window_q[i]) window_q[i] = '0;
		end else begin
			if (next_index >= 2 * WINDOW_LEN - 1 && (rolling_sum() & cut_mask) == cut_target) begin
				res.pos = POS_W'(next_index - WINDOW_LEN);
				res.fin = 1'b0;
				found = 1'b1;
			end
			if (next_index < MAX_LEN - 1) next_index++;
		end
		return found;
	endfunction

	task automatic report_mismatch(input string msg);
		if (errors < 100) $display("%0t MISMATCH: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		boundary_t want;
		logic hit;
		if (!arst_n) begin
			foreach (window_q[i]) window_q[i] = '0;
			next_index = '0;
			cut_target = TARGET_RESET;
			cut_mask = MASK_RESET;
			boundary_fifo.delete();
			errors = 0;
			byte_total = 0;
			cut_total = 0;
			final_total = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MATCH_TARGET: cut_target = cfg_data;
					REG_MATCH_MASK:   cut_mask = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				byte_total++;
				hit = absorb_byte(data_byte, is_last, want);
				if (hit) boundary_fifo.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (is_final) final_total++;
				else cut_total++;
				if (boundary_fifo.size() == 0) begin
					report_mismatch($sformatf("unexpected boundary word, position %0d final %0b",
						boundary_pos, is_final));
				end else begin
					want = boundary_fifo.pop_front();
					if (boundary_pos !== want.pos)
						report_mismatch($sformatf("boundary position %0d, expected %0d",
							boundary_pos, want.pos));
					if (is_final !== want.fin)
						report_mismatch($sformatf("final flag %0b at position %0d, expected %0b",
							is_final, want.pos, want.fin));
				end
			end
		end
		mismatch_count <= errors;
		pending_count <= boundary_fifo.size();
		bytes_seen <= byte_total;
		cuts_seen <= cut_total;
		finals_seen <= final_total;
	end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench top for the chunk boundary finder: clock, reset, byte buffers, match settings and
// random idling on both channels. Depends on cdcb_pkg, cdcb_checker and the block itself.
module tb;
	import cdcb_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 1000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [BYTE_W-1:0]     data_byte;
	logic                  is_last;
	logic                  out_valid;
	logic                  out_stall;
	logic [POS_W-1:0]      boundary_pos;
	logic                  is_final;
	int                    mismatch_count;
	int                    pending_count;
	int                    bytes_seen;
	int                    cuts_seen;
	int                    finals_seen;

	int idle_pct;
	bit draining;
	int buffer_total;
	int setting_total;

	content_defined_chunk_boundary_core dut (.*);
	cdcb_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_word(input logic [BYTE_W-1:0] b, input logic l);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		is_last <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_buffer(input int len);
		int style;
		logic [BYTE_W-1:0] fill;
		logic [BYTE_W-1:0] alt;
		logic [BYTE_W-1:0] b;
		style = $urandom_range(9);
		fill = $urandom_range(1) ? BYTE_W'(0) : BYTE_W'($urandom);
		alt = BYTE_W'($urandom);
		for (int i = 0; i < len; i++) begin
			if (style < 6) b = BYTE_W'($urandom);
			else if (style < 8) b = fill;
			else b = $urandom_range(1) ? fill : alt;
			send_word(b, i == len - 1);
		end
		buffer_total++;
	endtask

	function automatic int pick_length();
		case ($urandom_range(9))
			0: return $urandom_range(1, 3);
			1, 2: return $urandom_range(30, 34);
			default: return $urandom_range(35, 90);
		endcase
	endfunction

	task automatic settle();
		in_valid <= 1'b0;
		draining = 1'b1;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		draining = 1'b0;
	endtask

	task automatic program_match(input logic [HASH_W-1:0] target, input logic [HASH_W-1:0] mask,
			input bit spares);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_MATCH_TARGET;
		cfg_data <= target;
		@(posedge clk);
		cfg_index <= REG_MATCH_MASK;
		cfg_data <= mask;
		@(posedge clk);
		if (spares) begin
			for (int i = int'(REG_MATCH_MASK) + 1; i < 2 ** CFG_IDX_W; i++) begin
				cfg_index <= CFG_IDX_W'(i);
				cfg_data <= CFG_DATA_W'($urandom);
				@(posedge clk);
			end
		end
		cfg_wr_en <= 1'b0;
		setting_total++;
	endtask

	task automatic run_buffers(input int budget);
		int sent;
		int len;
		sent = 0;
		while (sent < budget) begin
			len = pick_length();
			send_buffer(len);
			sent += len;
			if ($urandom_range(7) == 0) settle();
		end
	endtask

	task automatic run_phase(input logic [HASH_W-1:0] target, input logic [HASH_W-1:0] mask,
			input int budget, input int idle_level, input bit spares);
		settle();
		program_match(target, mask, spares);
		idle_pct = idle_level;
		run_buffers(budget);
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_MATCH_TARGET;
		cfg_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		is_last = 1'b0;
		idle_pct = 0;
		draining = 1'b0;
		buffer_total = 3;
		setting_total = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b1);
		for (int i = 0; i < 20; i++) begin
			case (i % 4)
				0: send_word(8'h00, i == 19);
				1: send_word(8'hFF, i == 19);
				2: send_word(8'hA5, i == 19);
				default: send_word(8'h5A, i == 19);
			endcase
		end

		idle_pct = 20;
		run_buffers(60);
		run_phase(8'h00, 8'h00, 120, 25, 1'b1);
		run_phase(8'hFF, 8'hFF, 120, 0, 1'b0);
		run_phase(8'h80, 8'h0F, 80, 30, 1'b0);
		run_phase(8'h02, 8'h03, 170, 15, 1'b1);
		run_phase(8'($urandom_range(7)), 8'h07, 170, 25, 1'b0);
		run_phase(8'h00, 8'hFF, 120, 0, 1'b0);
		settle();

		$display("Covered %0d bytes in %0d buffers over %0d match settings, mask extremes included.",
			bytes_seen, buffer_total, setting_total);
		$display("Checked %0d chunk cuts and %0d closing boundaries; %0d mismatches.",
			cuts_seen, finals_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin : sink
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (draining || idle_pct == 0) stall_left = 0;
			else if (stall_left != 0) stall_left--;
			else if ($urandom_range(99) < idle_pct) stall_left = $urandom_range(1, 6);
			out_stall <= (stall_left != 0);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("Timeout: no word moved on either channel for %0d cycles.", QUIET_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

endmodule
